// ----- hdl/crce_pkg.sv -----
// Shared types, register codes and CRC step functions for the CRC engine.
package crce_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STEP_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CRC_WIDTH  = 2'd0,
    REG_POLYNOMIAL = 2'd1,
    REG_SEED       = 2'd2
  } reg_index_t;

  // Width codes; the unused code runs as 32 bits
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;

  localparam logic [DATA_W-1:0] POLY_RESET = 32'h04C1_1DB7;
  localparam logic [DATA_W-1:0] SEED_RESET = 32'h0000_0000;

  // One column of the word-update matrix per input bit
  typedef logic [DATA_W-1:0][DATA_W-1:0] col_array_t;

  typedef struct packed {
    logic [1:0]        crc_width;
    logic [DATA_W-1:0] seed;
    logic              busy;
  } cfg_t;

  function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] code);
    logic [DATA_W-1:0] m;
    unique case (code)
      WIDTH_8:  m = 32'h0000_00FF;
      WIDTH_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [STEP_W-1:0] width_steps(input logic [1:0] code);
    logic [STEP_W-1:0] n;
    unique case (code)
      WIDTH_8:  n = 6'd8;
      WIDTH_16: n = 6'd16;
      default:  n = 6'd32;
    endcase
    return n;
  endfunction

  // One shift with conditional polynomial XOR, masked to the width
  function automatic logic [DATA_W-1:0] crc_bit_step(input logic [DATA_W-1:0] v,
                                                     input logic [DATA_W-1:0] poly,
                                                     input logic [1:0]        code);
    logic              top;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] r;
    m = width_mask(code);
    unique case (code)
      WIDTH_8:  top = v[7];
      WIDTH_16: top = v[15];
      default:  top = v[31];
    endcase
    r = {v[DATA_W-2:0], 1'b0};
    if (top) begin
      r = r ^ poly;
    end
    return r & m;
  endfunction

endpackage

// ----- hdl/crce_matrix.sv -----
// Configuration registers and iterative build of the word-update matrix.
module crce_matrix import crce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output cfg_t                 cfg,
  output col_array_t           cols
);

  logic [1:0]        crc_width;
  logic [DATA_W-1:0] polynomial;
  logic [DATA_W-1:0] seed;
  logic              reload;
  logic              rebuild;
  logic [STEP_W-1:0] steps;
  col_array_t        cols_next;

  // a width or polynomial write restarts the matrix build
  assign rebuild = cfg_we && ((cfg_index == REG_CRC_WIDTH) || (cfg_index == REG_POLYNOMIAL));

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_width  <= WIDTH_32;
      polynomial <= POLY_RESET;
      seed       <= SEED_RESET;
      reload     <= 1'b1;
      steps      <= '0;
    end else begin
      reload <= rebuild;
      if (reload) begin
        steps <= width_steps(crc_width);
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
      end
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_CRC_WIDTH: begin
            crc_width <= cfg_data[1:0];
          end
          REG_POLYNOMIAL: begin
            polynomial <= cfg_data;
          end
          REG_SEED: begin
            seed <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      if (reload) begin
        cols_next[i] = (DATA_W'(1) << i) & width_mask(crc_width);
      end else begin
        cols_next[i] = crc_bit_step(cols[i], polynomial & width_mask(crc_width), crc_width);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (reload || (steps != '0)) begin
      cols <= cols_next;
    end
  end

  assign cfg.crc_width = crc_width;
  assign cfg.seed      = seed;
  assign cfg.busy      = reload || (steps != '0);

endmodule

// ----- hdl/crce_update.sv -----
// Input register, matrix word update, CRC state and result register.
module crce_update import crce_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  col_array_t        cols,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,
  input  logic              s_tlast,
  input  logic              s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata
);

  logic              in_valid;
  logic [DATA_W-1:0] in_data;
  logic              in_start;
  logic              in_last;
  logic [DATA_W-1:0] crc_register;
  logic [DATA_W-1:0] crc_next;
  logic [DATA_W-1:0] x;
  logic              out_free;
  logic              in_advance;
  logic              s_xfer;

  assign out_free   = !m_tvalid || m_tready;
  // words without last never wait on the result side
  assign in_advance = in_valid && (!in_last || out_free);
  assign s_tready   = !cfg.busy && (!in_valid || in_advance);
  assign s_xfer     = s_tvalid && s_tready;

  always_comb begin
    x = ((in_start ? cfg.seed : crc_register) ^ in_data) & width_mask(cfg.crc_width);
    crc_next = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (x[i]) begin
        crc_next = crc_next ^ cols[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      crc_register <= '0;
    end else begin
      if (s_xfer) begin
        in_valid <= 1'b1;
      end else if (in_advance) begin
        in_valid <= 1'b0;
      end
      if (in_advance) begin
        crc_register <= crc_next;
      end
      if (in_advance && in_last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_data  <= s_tdata;
      in_start <= s_tuser;
      in_last  <= s_tlast;
    end
    if (in_advance && in_last) begin
      m_tdata <= crc_next;
    end
  end

endmodule

// ----- hdl/crc_engine_8_16_32.sv -----
// Top level of the MSB-first CRC engine with 8, 16 or 32 bit width.
//
//   channel  | direction | handshake          | payload
//   s_*      | in        | s_tvalid/s_tready  | tdata=data_word, tuser=start_req, tlast=last
//   m_*      | out       | m_tvalid/m_tready  | tdata=crc_value
//   cfg_*    | in        | cfg_we             | cfg_index, cfg_data
//
// One word per cycle while no matrix build or stalled result holds the input; a
// last word passes the input register, then the result register. Width and
// polynomial are folded into a per-bit column matrix, built by the matrix unit
// one shift step per cycle. During that build, after reset or after a width or
// polynomial write, s_tready stays low. A stalled result holds only words marked last.
module crc_engine_8_16_32 import crce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [DATA_W-1:0]    s_tdata,   // [31:0] data_word
  input  logic                 s_tlast,
  input  logic                 s_tuser,   // [0] start_req
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,   // [31:0] crc_value
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  cfg_t       cfg;
  col_array_t cols;

  crce_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cols      (cols)
  );

  crce_update u_update (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cols     (cols),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- hdl/crce_checker.sv -----
// Port-level checks for the CRC engine and their binding to the top level.
module crce_checker import crce_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [DATA_W-1:0]    m_tdata,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // matrix rebuild follows reset
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready right after reset");

  // width or polynomial write blocks input until the matrix is rebuilt
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_CRC_WIDTH || cfg_index == REG_POLYNOMIAL) |=> !s_tready)
    else $error("input ready during matrix rebuild");

endmodule

bind crc_engine_8_16_32 crce_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);

// ----- sim/crc_engine_8_16_32_check.sv -----
// Checker for the CRC engine: follows register writes, predicts each CRC, compares results.
`timescale 1ns / 100ps

module crc_engine_8_16_32_check import crce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [DATA_W-1:0]    s_tdata,   // [31:0] data_word
  input  logic                 s_tlast,
  input  logic                 s_tuser,   // [0] start_req
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [DATA_W-1:0]    m_tdata,   // [31:0] crc_value
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   pending,
  output int                   mismatches
);

  logic [1:0]        width_code;
  logic [DATA_W-1:0] poly_reg;
  logic [DATA_W-1:0] seed_reg;
  logic [DATA_W-1:0] crc_acc;
  logic [DATA_W-1:0] due_crcs[$];
  logic [DATA_W-1:0] want;

  // Fold one word into the running CRC, one shift per bit of the width
  function automatic logic [DATA_W-1:0] advance_crc(input logic [DATA_W-1:0] acc,
                                                    input logic [DATA_W-1:0] word,
                                                    input logic [1:0]        code,
                                                    input logic [DATA_W-1:0] poly);
    int unsigned       nbits;
    logic [DATA_W-1:0] msk;
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] r;
    nbits = (code == WIDTH_8) ? 8 : (code == WIDTH_16) ? 16 : 32;
    msk = (nbits == 32) ? '1 : ((32'd1 << nbits) - 32'd1);
    top = 32'd1 << (nbits - 1);
    p = poly & msk;
    r = (acc & msk) ^ (word & msk);
    for (int k = 0; k < nbits; k++) begin
      if ((r & top) != 0) r = ((r << 1) ^ p) & msk;
      else r = (r << 1) & msk;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_code = WIDTH_32;
      poly_reg = POLY_RESET;
      seed_reg = SEED_RESET;
      crc_acc = '0;
      due_crcs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CRC_WIDTH:  width_code = cfg_data[1:0];
          REG_POLYNOMIAL: poly_reg = cfg_data;
          REG_SEED:       seed_reg = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        // a start reloads the seed; the width mask is applied inside the step
        crc_acc = advance_crc(s_tuser ? seed_reg : crc_acc, s_tdata, width_code, poly_reg);
        if (s_tlast) due_crcs.push_back(crc_acc);
      end
      if (m_tvalid && m_tready) begin
        if (due_crcs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("crc result %08h with nothing due", m_tdata);
        end else begin
          want = due_crcs.pop_front();
          if (m_tdata !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("crc_value mismatch: expected %08h, got %08h", want, m_tdata);
            end
          end
        end
      end
    end
    pending <= due_crcs.size();
  end

endmodule

// ----- sim/crc_engine_8_16_32_test.sv -----
// Stimulus and verdict for the CRC engine: directed buffers, then random buffers and settings.
`timescale 1ns / 100ps

module crc_engine_8_16_32_test;
  import crce_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind this index
  localparam int unsigned ITEM_TARGET = 650;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [DATA_W-1:0]    s_tdata = '0;   // [31:0] data_word
  logic                 s_tlast = 1'b0;
  logic                 s_tuser = 1'b0; // [0] start_req
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [DATA_W-1:0]    m_tdata;        // [31:0] crc_value
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  int          pending;
  int          mismatches;
  bit          calm = 1'b0;
  int unsigned words_sent = 0;

  crc_engine_8_16_32 u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  crc_engine_8_16_32_check u_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .mismatches(mismatches)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones; none while calm
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic send_word(input logic [DATA_W-1:0] word, input logic start_bit,
                           input logic last_bit);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= start_bit;
    s_tlast  <= last_bit;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every CRC due has been taken, plus the pipeline depth
  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [1:0] code, input logic [DATA_W-1:0] poly,
                             input logic [DATA_W-1:0] seed_val);
    logic [DATA_W-1:0] junk;
    junk = $urandom;
    wait_results_done();
    write_reg(REG_SPARE, $urandom);
    // upper bits of the width write carry noise; only the low two count
    write_reg(REG_CRC_WIDTH, {junk[DATA_W-1:2], code});
    write_reg(REG_POLYNOMIAL, poly);
    write_reg(REG_SEED, seed_val);
    cfg_we <= 1'b0;
  endtask

  // Receiver: ready for a while, then a random stall
  initial begin
    int unsigned gap;
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned phase_end;
    int unsigned len;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: 32-bit, standard polynomial, zero seed
    send_word(32'h0000_0000, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_word(32'h1234_5678, 1'b1, 1'b0);
    send_word(32'h8000_0001, 1'b0, 1'b0);
    send_word(32'hA5A5_A5A5, 1'b0, 1'b1);
    send_word(32'h0000_0001, 1'b0, 1'b1);  // continue without a start
    send_word(32'hDEAD_BEEF, 1'b1, 1'b0);  // leave the buffer open

    // Narrow the width with the buffer still open
    reconfigure(WIDTH_8, 32'hFFFF_FF07, 32'hFFFF_FFAB);
    send_word(32'h1234_5681, 1'b0, 1'b1);
    send_word(32'h0000_00FF, 1'b1, 1'b1);
    send_word(32'hFFFF_FF00, 1'b1, 1'b1);
    send_word(32'h5A5A_5A80, 1'b1, 1'b0);
    send_word(32'h0000_0001, 1'b0, 1'b1);

    reconfigure(WIDTH_16, 32'h0000_1021, 32'h0000_FFFF);
    send_word(32'hFFFF_8000, 1'b1, 1'b0);
    send_word(32'h0000_FFFF, 1'b0, 1'b1);
    send_word(32'h7FFF_0000, 1'b1, 1'b1);

    // Unused width code runs as 32 bits
    reconfigure(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'h0000_0000, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1, 1'b1);

    reconfigure(WIDTH_32, 32'h0000_0000, 32'h1234_5678);
    send_word(32'h8765_4321, 1'b1, 1'b1);
    send_word(32'h0000_0000, 1'b0, 1'b1);

    while (words_sent < ITEM_TARGET) begin
      reconfigure(2'($urandom_range(0, 3)), pick_value(), pick_value());
      calm = ($urandom_range(0, 4) == 0);
      phase_end = words_sent + $urandom_range(30, 90);
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(pick_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            send_word(pick_value(), k == 0, k == len - 1);
          end
        end
        if ($urandom_range(0, 29) == 0) wait_results_done();
      end
      calm = 1'b0;
    end

    wait_results_done();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
